// ===== hdl/sma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

  // Window storage and arithmetic widths
  localparam int MAX_WINDOW = 256;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int CENTS_W    = 32;
  localparam int TOTAL_W    = CENTS_W + SLOT_W;
  localparam int DIV_W      = TOTAL_W + 2;
  localparam int DEN_W      = CNT_W + 1;
  localparam int STEP_W     = $clog2(DIV_W);

  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(20);
  localparam logic [CNT_W-1:0] WINDOW_MAX   = CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] WINDOW_MIN   = CNT_W'(1);

  // Trend codes
  localparam logic [1:0] TREND_NEUTRAL = 2'd0;
  localparam logic [1:0] TREND_BULLISH = 2'd1;
  localparam logic [1:0] TREND_BEARISH = 2'd2;

  typedef struct packed {
    logic                 start_series;
    logic [CENTS_W-1:0]   close_cents;
  } sma_in_t;

  typedef struct packed {
    logic [CENTS_W-1:0]   average_cents;
    logic [1:0]           trend_signal;
  } sma_out_t;

  // Work handed from the window keeper to the divider
  typedef struct packed {
    logic [TOTAL_W-1:0]   total;
    logic [CNT_W-1:0]     count;
    logic [CENTS_W-1:0]   close_cents;
  } sma_job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RD,
    F_UPD,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/sma_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sma_front import sma_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire sma_in_t          in_item,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             q_full,
  output logic                  q_push,
  output sma_job_t              q_data
);

  front_state_t         state, state_next;
  logic [CNT_W-1:0]     window_size;
  logic [CNT_W-1:0]     win_eff;
  logic [SLOT_W-1:0]    slot;
  logic [CNT_W-1:0]     held;
  logic [TOTAL_W-1:0]   total;
  logic [CENTS_W-1:0]   close_cents;
  logic                 drop;
  logic [CENTS_W-1:0]   old_sample;
  logic [CENTS_W-1:0]   ring [MAX_WINDOW];
  logic                 accept;

  assign accept = push && !full;

  // Clamp the window register into its legal range
  always_comb begin
    win_eff = window_size;
    if (window_size < WINDOW_MIN) win_eff = WINDOW_MIN;
    if (window_size > WINDOW_MAX) win_eff = WINDOW_MAX;
  end

  // Hold the window register
  always_ff @(posedge clk) begin
    if (rst) window_size <= WINDOW_RESET;
    else if (cfg_we) window_size <= cfg_wdata;
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (accept) state_next = F_RD;
      F_RD:    state_next = F_UPD;
      F_UPD:   state_next = F_PUSH;
      F_PUSH:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != F_IDLE);
    q_push = (state == F_PUSH) && !q_full;
  end

  assign q_data = '{total: total, count: held, close_cents: close_cents};

  // Read the oldest sample, then store the new one and update the sum
  always_ff @(posedge clk) begin
    if (state == F_RD) begin
      old_sample <= ring[slot - held[SLOT_W-1:0]];
      drop       <= (held >= win_eff);
    end
    if (state == F_UPD) ring[slot] <= close_cents;
    if (accept) close_cents <= in_item.close_cents;
  end

  // Keep the window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= '0;
      held  <= '0;
      total <= '0;
    end else if (accept && in_item.start_series) begin
      slot  <= '0;
      held  <= '0;
      total <= '0;
    end else if (state == F_UPD) begin
      slot  <= slot + SLOT_W'(1);
      total <= total - (drop ? TOTAL_W'(old_sample) : '0) + TOTAL_W'(close_cents);
      held  <= drop ? held : held + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sma_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sma_queue import sma_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr,
  input  wire sma_job_t wdata,
  output logic          full,
  input  wire logic     rd,
  output sma_job_t      rdata,
  output logic          empty
);

  sma_job_t    entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign rdata = entry[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (wr && !full) entry[wr_ptr] <= wdata;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr && !full) wr_ptr <= !wr_ptr;
      if (rd && !empty) rd_ptr <= !rd_ptr;
      fill <= fill + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sma_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sma_back import sma_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_empty,
  input  wire sma_job_t q_data,
  output logic          q_pop,
  output logic          empty,
  input  wire logic     pop,
  output sma_out_t      out_item
);

  back_state_t        state, state_next;
  logic [DIV_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W:0]     rem_sh;
  logic               q_bit;
  logic [STEP_W-1:0]  step;
  logic [CENTS_W-1:0] close_cents;
  logic [CENTS_W-1:0] avg;
  logic               res_valid;
  logic               res_load;
  logic               last_step;

  assign avg       = num[CENTS_W-1:0];
  assign last_step = (step == STEP_W'(DIV_W - 1));
  assign res_load  = (state == B_DONE) && (!res_valid || pop);

  // Advance the divider sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_empty) state_next = B_DIV;
      B_DIV:   if (last_step) state_next = B_DONE;
      B_DONE:  if (!res_valid || pop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    empty = !res_valid;
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem, num[DIV_W-1]};
    q_bit  = (rem_sh >= {1'b0, den});
  end

  // Load (2*total + count) / (2*count) and iterate one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      num         <= {1'b0, q_data.total, 1'b0} + DIV_W'(q_data.count);
      den         <= {q_data.count, 1'b0};
      rem         <= '0;
      step        <= '0;
      close_cents <= q_data.close_cents;
    end else if (state == B_DIV) begin
      rem  <= q_bit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      num  <= {num[DIV_W-2:0], q_bit};
      step <= step + STEP_W'(1);
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (res_load) res_valid <= 1'b1;
    else if (pop) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item.average_cents <= avg;
      if (close_cents > avg) out_item.trend_signal <= TREND_BULLISH;
      else if (close_cents < avg) out_item.trend_signal <= TREND_BEARISH;
      else out_item.trend_signal <= TREND_NEUTRAL;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/simple_moving_average_signal_core.sv =====
// Moving average of closing prices in cents, with a trend flag comparing each close against
// its rounded mean (halves up; early results average the partial window). Items enter through
// a queue-style push/full port and results leave through empty/pop. A window keeper takes an
// item, reads its oldest sample from memory, updates the sum and hands the job off; a two-entry
// queue feeds a bit-serial divider (load, quotient loop, result). Neither half takes a new item
// before it is through with the last. window_size is written by cfg_we/cfg_wdata; write it only
// while idle, as the block does not enforce this; 0 acts as 1 and values above 256 as 256.
`timescale 1ns / 1ps
`default_nettype none

module simple_moving_average_signal_core import sma_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire sma_in_t          in_item,
  output logic                  empty,
  input  wire logic             pop,
  output sma_out_t              out_item,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  sma_job_t fe_job;
  sma_job_t be_job;
  logic     fe_push;
  logic     q_full;
  logic     q_empty;
  logic     be_pop;

  // Accept items and keep the window
  sma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (fe_push),
    .q_data    (fe_job)
  );

  // Decouple the two halves
  sma_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (fe_push),
    .wdata (fe_job),
    .full  (q_full),
    .rd    (be_pop),
    .rdata (be_job),
    .empty (q_empty)
  );

  // Divide and classify
  sma_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (be_job),
    .q_pop    (be_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== verif/simple_moving_average_signal_core_tb.sv =====
`timescale 1ns / 1ps

module simple_moving_average_signal_core_tb;
  import sma_pkg::*;

  localparam int ITEM_TARGET     = 1750;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_OFF_CYCLES = 800;
  localparam int SETTLE_CYCLES   = 100;
  localparam int N_ROWS          = 24;
  localparam int PRINT_LIMIT     = 20;

  typedef enum {DRAIN_ALWAYS, DRAIN_COIN, DRAIN_PATTERN, DRAIN_TRICKLE} drain_mode_t;

  // One directed transaction, with an optional window write ahead of it
  typedef struct packed {
    bit               set_window;
    bit [CNT_W-1:0]   window;
    bit               start;
    bit [CENTS_W-1:0] close;
    bit               has_lit;
    bit [CENTS_W-1:0] lit_avg;
    bit [1:0]         lit_trend;
  } price_row_t;

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  sma_in_t          in_item;
  logic             empty;
  logic             pop;
  sma_out_t         out_item;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  // Hand-typed expectation riding along with a directed transaction
  logic     lit_valid;
  sma_out_t lit_result;

  // Predictor state
  logic [CENTS_W-1:0] avg_ring [MAX_WINDOW];
  logic [SLOT_W-1:0]  avg_slot;
  logic [CNT_W-1:0]   avg_held;
  logic [TOTAL_W-1:0] avg_total;
  logic [CNT_W-1:0]   avg_window;
  sma_out_t           avg_expect_q [$];

  int  items_sent;
  int  results_seen;
  int  err_count;
  int  stall_cycles;
  int  windows_written;
  int  neutral_seen;
  int  bullish_seen;
  int  bearish_seen;
  bit  push_drive;
  bit  gaps_on;
  int  burst_left;
  bit  hold_off_req;

  price_row_t price_rows [N_ROWS] = '{
    '{0, 0,   1, 32'd0,           1, 32'd0,           TREND_NEUTRAL},
    '{0, 0,   0, 32'hFFFF_FFFF,   1, 32'h8000_0000,   TREND_BULLISH},
    '{0, 0,   0, 32'd0,           0, 32'd0,           TREND_NEUTRAL},
    '{1, 1,   0, 32'd100,         0, 32'd0,           TREND_NEUTRAL},
    '{0, 0,   0, 32'd101,         0, 32'd0,           TREND_NEUTRAL},
    '{0, 0,   0, 32'd102,         0, 32'd0,           TREND_NEUTRAL},
    '{1, 0,   1, 32'd12345,       1, 32'd12345,       TREND_NEUTRAL},
    '{0, 0,   0, 32'd7,           1, 32'd7,           TREND_NEUTRAL},
    '{1, 511, 1, 32'hFFFF_FFFF,   1, 32'hFFFF_FFFF,   TREND_NEUTRAL},
    '{0, 0,   0, 32'hFFFF_FFFF,   1, 32'hFFFF_FFFF,   TREND_NEUTRAL},
    '{0, 0,   0, 32'hFFFF_FFFE,   0, 32'd0,           TREND_NEUTRAL},
    '{1, 256, 1, 32'd1,           1, 32'd1,           TREND_NEUTRAL},
    '{0, 0,   0, 32'd2,           1, 32'd2,           TREND_NEUTRAL},
    '{0, 0,   0, 32'd0,           1, 32'd1,           TREND_BEARISH},
    '{1, 2,   1, 32'd1,           1, 32'd1,           TREND_NEUTRAL},
    '{0, 0,   0, 32'd0,           1, 32'd1,           TREND_BEARISH},
    '{0, 0,   0, 32'd3,           1, 32'd2,           TREND_BULLISH},
    '{1, 3,   0, 32'd10,          0, 32'd0,           TREND_NEUTRAL},
    '{0, 0,   0, 32'd10,          0, 32'd0,           TREND_NEUTRAL},
    '{0, 0,   0, 32'd10,          0, 32'd0,           TREND_NEUTRAL},
    '{1, 20,  1, 32'd500,         1, 32'd500,         TREND_NEUTRAL},
    '{0, 0,   0, 32'd300,         1, 32'd400,         TREND_BEARISH},
    '{0, 0,   1, 32'h8000_0001,   1, 32'h8000_0001,   TREND_NEUTRAL},
    '{1, 257, 0, 32'd5,           0, 32'd0,           TREND_NEUTRAL}
  };

  simple_moving_average_signal_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simple_moving_average_signal_core_tb NOT OK");
    $finish;
  end

  // Advance the window by one close and return the rounded mean and trend
  function automatic sma_out_t advance_average(logic start, logic [CENTS_W-1:0] close);
    int                 win;
    logic [SLOT_W-1:0]  oldest;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        mean;
    sma_out_t           res;
    if (start) begin
      avg_slot  = '0;
      avg_held  = '0;
      avg_total = '0;
    end
    win = int'(avg_window);
    if (win < 1) win = 1;
    if (win > MAX_WINDOW) win = MAX_WINDOW;
    // Drop the oldest sample first; the write may land on its slot
    if (int'(avg_held) + 1 > win && avg_held != '0) begin
      oldest    = avg_slot - avg_held[SLOT_W-1:0];
      avg_total = avg_total - TOTAL_W'(avg_ring[oldest]);
      avg_held  = avg_held - CNT_W'(1);
    end
    avg_ring[avg_slot] = close;
    avg_total = avg_total + TOTAL_W'(close);
    if (avg_held < WINDOW_MAX) avg_held = avg_held + CNT_W'(1);
    avg_slot = avg_slot + SLOT_W'(1);
    // Round to nearest cent, halves up
    num  = (64'(avg_total) << 1) + 64'(avg_held);
    den  = 64'(avg_held) << 1;
    mean = num / den;
    res.average_cents = mean[CENTS_W-1:0];
    if (close > mean[CENTS_W-1:0]) res.trend_signal = TREND_BULLISH;
    else if (close < mean[CENTS_W-1:0]) res.trend_signal = TREND_BEARISH;
    else res.trend_signal = TREND_NEUTRAL;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [CENTS_W-1:0] got, logic [CENTS_W-1:0] want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Track config, predict accepted transactions, check popped results
  always @(posedge clk) begin : monitor
    sma_out_t predicted;
    sma_out_t want;
    if (rst) begin
      avg_slot   = '0;
      avg_held   = '0;
      avg_total  = '0;
      avg_window = WINDOW_RESET;
    end else begin
      if (cfg_we) avg_window = cfg_wdata;
      if (push && full) stall_cycles++;
      if (push && !full) begin
        predicted = advance_average(in_item.start_series, in_item.close_cents);
        if (lit_valid) predicted = lit_result;
        avg_expect_q.insert(avg_expect_q.size(), predicted);
      end
      if (pop && !empty) begin
        results_seen++;
        case (out_item.trend_signal)
          TREND_NEUTRAL: neutral_seen++;
          TREND_BULLISH: bullish_seen++;
          TREND_BEARISH: bearish_seen++;
          default: ;
        endcase
        if (avg_expect_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_item.average_cents, '0);
        end else begin
          want = avg_expect_q[0];
          avg_expect_q.delete(0);
          if (out_item.average_cents !== want.average_cents)
            report_mismatch("average_cents", out_item.average_cents, want.average_cents);
          if (out_item.trend_signal !== want.trend_signal)
            report_mismatch("trend_signal", CENTS_W'(out_item.trend_signal),
                            CENTS_W'(want.trend_signal));
        end
      end
    end
  end

  // Receiver: pop on a changing pattern, with a long hold-off on request
  initial begin : receiver
    drain_mode_t mode;
    int          span;
    int          hold_left;
    bit [7:0]    pat;
    pop       <= 1'b0;
    mode      = DRAIN_ALWAYS;
    span      = 0;
    hold_left = 0;
    pat       = '1;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = drain_mode_t'($urandom_range(0, 3));
          span = $urandom_range(32, 256);
          pat  = 8'($urandom) | 8'h01;
        end
        span--;
        case (mode)
          DRAIN_ALWAYS: pop <= 1'b1;
          DRAIN_COIN:   pop <= 1'($urandom_range(0, 1));
          DRAIN_PATTERN: begin
            pop <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
          default: pop <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic lower_push();
    if (push_drive) begin
      push <= 1'b0;
      push_drive = 1'b0;
    end
  endtask

  // Offer one transaction, hold it until accepted, then pace the next one
  task automatic send_price(bit start, bit [CENTS_W-1:0] close, bit has_lit, sma_out_t lit);
    push       <= 1'b1;
    push_drive = 1'b1;
    in_item    <= '{start_series: start, close_cents: close};
    lit_valid  <= has_lit;
    lit_result <= lit;
    do @(posedge clk); while (full);
    items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        lower_push();
        repeat ($urandom_range(1, 40)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_results();
    lower_push();
    while (results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_window(bit [CNT_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    windows_written++;
  endtask

  // Sender: reset, directed table, random phases, wind-down
  initial begin : sender
    price_row_t       row;
    sma_out_t         lit;
    bit [CNT_W-1:0]   win_val;
    bit [CENTS_W-1:0] base;
    bit [CENTS_W-1:0] close;
    bit               series_open;
    bit               flat;
    bit               start_bit;
    int               eff;
    int               len;
    int               phase_no;
    int               r;
    rst        <= 1'b1;
    push       <= 1'b0;
    in_item    <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    lit_valid  <= 1'b0;
    lit_result <= '0;
    push_drive = 1'b0;
    gaps_on    = 1'b1;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: extremes, rounding, window clamping, shrink and grow
    for (int i = 0; i < N_ROWS; i++) begin
      row = price_rows[i];
      if (row.set_window) write_window(row.window);
      lit.average_cents = row.lit_avg;
      lit.trend_signal  = row.lit_trend;
      send_price(row.start, row.close, row.has_lit, lit);
    end

    // Random phases: one window setting each, mostly one well-formed series
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase_no)
        0: win_val = CNT_W'(256);
        1: win_val = CNT_W'(511);
        2: win_val = CNT_W'(1);
        3: win_val = CNT_W'(0);
        4: win_val = CNT_W'(257);
        5: win_val = CNT_W'(255);
        default: begin
          r = $urandom_range(0, 9);
          if (r < 6) win_val = CNT_W'($urandom_range(1, 32));
          else win_val = CNT_W'($urandom_range(0, 511));
        end
      endcase
      write_window(win_val);
      eff = (win_val == 0) ? 1 : (win_val > MAX_WINDOW) ? MAX_WINDOW : int'(win_val);
      len = (phase_no < 2) ? eff + $urandom_range(20, 120) : $urandom_range(12, 80);
      gaps_on = ($urandom_range(0, 2) != 0);
      // Hold the receiver off while the sender streams, so the input stalls
      if (phase_no == 3) begin
        hold_off_req = 1'b1;
        gaps_on      = 1'b0;
      end
      series_open = ($urandom_range(0, 4) != 0) || (phase_no == 0);
      base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(100, 500000);
      flat = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        start_bit = (i == 0 && series_open) || ($urandom_range(0, 49) == 0);
        r = $urandom_range(0, 99);
        if (r < 12) close = $urandom;
        else if (r < 16) close = $urandom_range(0, 1) ? '1 : '0;
        else if (flat) close = base;
        else close = base + $urandom_range(0, 40) - 20;
        send_price(start_bit, close, 1'b0, '0);
        // Pause mid-series until everything has come back
        if (phase_no == 5 && i == len / 2) drain_results();
      end
      phase_no++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d transactions over %0d window writes; input held off for %0d cycles",
             items_sent, windows_written, stall_cycles);
    $display("trends returned: %0d neutral, %0d bullish, %0d bearish",
             neutral_seen, bullish_seen, bearish_seen);
    if (err_count == 0 && avg_expect_q.size() == 0)
      $display("simple_moving_average_signal_core_tb OK");
    else
      $display("simple_moving_average_signal_core_tb NOT OK");
    $finish;
  end

endmodule
